@@ design/zssd_pkg.sv @@
// Shared constants and types for the zero-sum subarray detector.
`timescale 1ns / 1ps
package zssd_pkg;

  // Width of one input value and of the wrapping prefix sum.
  localparam int VALUE_W = 31;
  localparam int SUM_W   = 48;

  // Capacity of the prefix-sum store and the widths that follow from it.
  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } entry_t;

endpackage

@@ design/zssd_front.sv @@
// Front part: accepts items and forms the alternating prefix sum.
`timescale 1ns / 1ps
module zssd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [zssd_pkg::VALUE_W-1:0] value,
  input  logic                   last,
  input  logic                   q_full,
  output logic                   push,
  output zssd_pkg::entry_t       push_entry
);
  import zssd_pkg::*;

  logic [SUM_W-1:0] running_sum;
  logic             odd_position;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] value_ext;

  // Even positions subtract the value, odd positions add it.
  assign value_ext = {{(SUM_W - VALUE_W){1'b0}}, value};
  always_comb begin
    if (odd_position) begin
      sum_next = running_sum + value_ext;
    end else begin
      sum_next = running_sum - value_ext;
    end
  end

  // An item is taken whenever the queue has room.
  assign in_ready        = !q_full;
  assign push            = in_valid && !q_full;
  assign push_entry.sum  = sum_next;
  assign push_entry.last = last;

  // The running sum returns to zero after the last item of a sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      odd_position <= 1'b0;
    end else if (push) begin
      if (last) begin
        running_sum  <= '0;
        odd_position <= 1'b0;
      end else begin
        running_sum  <= sum_next;
        odd_position <= !odd_position;
      end
    end
  end

endmodule

@@ design/zssd_queue.sv @@
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps
module zssd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  zssd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output zssd_pkg::entry_t head,
  output logic             empty
);
  import zssd_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_pop;

  assign full   = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty  = (fill == '0);
  assign do_pop = pop && !empty;
  assign head   = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ design/zssd_back.sv @@
// Back part: scans the stored prefix sums, stores the new one and forms the result.
`timescale 1ns / 1ps
module zssd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  zssd_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic             overflow
);
  import zssd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_CMP    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state;
  logic [SUM_W-1:0]  cur_sum;
  logic              cur_last;
  logic [ADDR_W-1:0] scan_addr;
  logic              rd_pend;
  logic [SUM_W-1:0]  rd_data;
  logic [CNT_W-1:0]  stored_count;
  logic              hit_seen;
  logic              capacity_exceeded;
  logic [SUM_W-1:0]  seen_sums [MAX_ITEMS];

  logic              store_full;
  logic              scan_end;
  logic              match;
  logic              can_finish;
  logic              mem_we;
  logic              load_out;
  logic              skip_scan;

  // Decode of the current step.
  assign store_full = (stored_count == CNT_W'(MAX_ITEMS));
  assign scan_end   = ({1'b0, scan_addr} + 1'b1) == stored_count;
  assign match      = rd_pend && (rd_data == cur_sum);
  assign can_finish = !cur_last || !out_valid || out_ready;
  assign pop        = (state == S_IDLE) && !q_empty;
  assign skip_scan  = hit_seen || (head.sum == '0) || (stored_count == '0);
  assign mem_we     = (state == S_FINISH) && can_finish && !store_full;
  assign load_out   = (state == S_FINISH) && can_finish && cur_last;

  // Prefix-sum store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seen_sums[stored_count[ADDR_W-1:0]] <= cur_sum;
    end
    rd_data <= seen_sums[scan_addr];
  end

  // Sequencer and sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      scan_addr         <= '0;
      rd_pend           <= 1'b0;
      stored_count      <= '0;
      hit_seen          <= 1'b0;
      capacity_exceeded <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            scan_addr <= '0;
            if (skip_scan) begin
              if (head.sum == '0) begin
                hit_seen <= 1'b1;
              end
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_seen <= 1'b1;
          end
          if (scan_end) begin
            state <= S_CMP;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_CMP: begin
          if (match) begin
            hit_seen <= 1'b1;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (can_finish) begin
            if (cur_last) begin
              out_valid         <= 1'b1;
              stored_count      <= '0;
              hit_seen          <= 1'b0;
              capacity_exceeded <= 1'b0;
            end else if (store_full) begin
              capacity_exceeded <= 1'b1;
            end else begin
              stored_count <= stored_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: the current item and the result.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_sum  <= head.sum;
      cur_last <= head.last;
    end
    if (load_out) begin
      found    <= hit_seen;
      overflow <= capacity_exceeded || store_full;
    end
  end

  // The scan only runs over a store that holds at least one sum.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (stored_count != '0))
    else $error("scan started on an empty store");

  // The store is never written beyond its capacity.
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (stored_count < CNT_W'(MAX_ITEMS)))
    else $error("store written past capacity");

  // Emitting a result clears the sequence state.
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> (stored_count == '0) && !hit_seen && !capacity_exceeded && out_valid)
    else $error("sequence state not cleared after result");

  // A last item waits while the previous result is still held.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && cur_last && out_valid && !out_ready) |=> (state == S_FINISH))
    else $error("result overwritten while stalled");

endmodule

@@ design/zero_sum_subarray_detect_unit.sv @@
// Top level of the zero-sum alternating subarray detector.
//
// Input channel: value and last with in_valid / in_ready. Values at even
// positions of a sequence are negated and a 48-bit prefix sum is kept.
// Output channel: found and overflow with out_valid / out_ready, one result
// for each item that carries last.
// The front takes an item in the cycle it is offered while the four-entry
// queue has room. The back then compares the item's prefix sum with every
// stored sum, one store read per cycle, and skips the scan once a hit is
// known, when the sum is zero or when the store is empty. The single read
// port of the prefix-sum store sets the speed of this scan.
// Reset clears the sequence state and the queue; the store needs no clearing
// pass since only entries below the fill count are read.
// When the receiver stalls, the result stays in the output register, the back
// holds a further last item, and the queue fills until in_ready falls.
`timescale 1ns / 1ps
module zero_sum_subarray_detect_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [zssd_pkg::VALUE_W-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic                         overflow
);
  import zssd_pkg::*;

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  // Accept items and form prefix sums.
  zssd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple the front from the back.
  zssd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  // Compare, store and report.
  zssd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .overflow  (overflow)
  );

endmodule
